// File: hdl/drti_pkg.sv
// Package for double_round_to_integral: mode codes, field constants and
// the stage-to-stage record types. No dependencies.
package drti_pkg;
  typedef enum logic [2:0] {
    MODE_FLOOR = 3'd0,
    MODE_CEIL  = 3'd1,
    MODE_TRUNC = 3'd2,
    MODE_HALF_AWAY = 3'd3,
    MODE_HALF_EVEN = 3'd4
  } mode_t;

  localparam logic [10:0] BIAS = 11'd1023;
  localparam logic [10:0] EXP_INT = 11'd1075;
  localparam logic [10:0] EXP_MAX = 11'h7ff;
  localparam logic [63:0] ONE_BITS = 64'h3ff0000000000000;

  // stage 1 -> stage 2
  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] x;
    logic        pass;
    logic        below_one;
    logic [5:0]  fb;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic [63:0] x;
    logic        done;
    logic [63:0] early;
    logic        inc;
    logic [52:0] ipart;
    logic [5:0]  fb;
  } s2_t;
endpackage

// File: hdl/drti_if.sv
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
interface drti_if #(parameter int W = 64) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/drti_decode.sv
// Stage 1 logic: classify the operand and compute the fraction bit count.
// Depends on drti_pkg.
module drti_decode (
  input  logic [2:0]       mode,
  input  logic [63:0]      x,
  output drti_pkg::s1_t    s1
);
  import drti_pkg::*;
  logic [10:0] bexp;
  logic [10:0] fbw;
  always_comb begin
    bexp = x[62:52];
    fbw = EXP_INT - bexp;
    s1.mode = mode;
    s1.x = x;
    s1.pass = (mode > MODE_HALF_EVEN) || (x[62:0] == 63'd0) || (bexp == EXP_MAX) ||
              (bexp >= EXP_INT);
    s1.below_one = bexp < BIAS;
    s1.fb = fbw[5:0];
  end
endmodule

// File: hdl/drti_decide.sv
// Stage 2 logic: split integer/fraction, choose increment, resolve |x|<1.
// Depends on drti_pkg.
module drti_decide (
  input  drti_pkg::s1_t s1,
  output drti_pkg::s2_t s2
);
  import drti_pkg::*;
  logic [52:0] mant, fmask, frac, half;
  logic        neg, up;
  always_comb begin
    neg = s1.x[63];
    mant = {1'b1, s1.x[51:0]};
    fmask = (53'd1 << s1.fb) - 53'd1;
    frac = mant & fmask;
    half = 53'd1 << (s1.fb - 6'd1);
    s2.x = s1.x;
    s2.fb = s1.fb;
    s2.ipart = mant & ~fmask;
    s2.done = 1'b0;
    s2.early = s1.x;
    s2.inc = 1'b0;
    up = 1'b0;
    if (s1.pass) begin
      s2.done = 1'b1;
    end else if (s1.below_one) begin
      s2.done = 1'b1;
      case (s1.mode)
        MODE_FLOOR: s2.early = neg ? {1'b1, ONE_BITS[62:0]} : 64'd0;
        MODE_CEIL:  s2.early = neg ? 64'd0 : ONE_BITS;
        MODE_TRUNC: s2.early = 64'd0;
        MODE_HALF_AWAY:
          s2.early = (s1.x[62:52] == BIAS - 11'd1) ? {neg, ONE_BITS[62:0]} : 64'd0;
        default: begin
          up = (s1.x[62:52] == BIAS - 11'd1) && (s1.x[51:0] != 52'd0);
          s2.early = up ? {neg, ONE_BITS[62:0]} : {neg, 63'd0};
        end
      endcase
    end else if (frac == 53'd0) begin
      s2.done = 1'b1;
    end else begin
      case (s1.mode)
        MODE_FLOOR: s2.inc = neg;
        MODE_CEIL:  s2.inc = !neg;
        MODE_TRUNC: s2.inc = 1'b0;
        MODE_HALF_AWAY: s2.inc = frac >= half;
        default: s2.inc = (frac > half) || ((frac == half) && mant[s1.fb]);
      endcase
    end
  end
endmodule

// File: hdl/drti_assemble.sv
// Stage 3 logic: apply increment, renormalize on carry, pack the result.
// Depends on drti_pkg.
module drti_assemble (
  input  drti_pkg::s2_t s2,
  output logic [63:0]   y
);
  import drti_pkg::*;
  logic [53:0] sum;
  logic [10:0] bexp;
  always_comb begin
    sum = {1'b0, s2.ipart} + (s2.inc ? (54'd1 << s2.fb) : 54'd0);
    bexp = s2.x[62:52];
    if (sum[53]) begin
      bexp = bexp + 11'd1;
    end
    if (s2.done) begin
      y = s2.early;
    end else begin
      y = {s2.x[63], bexp, sum[51:0]};
    end
  end
endmodule

// File: hdl/double_round_to_integral.sv
// Round a binary64 value to an integral binary64 value, five modes.
// An accepted request passes the decode, decide and assemble registers in
// turn before its result is valid. Throughput: one request per cycle; a
// stalled output holds the whole pipeline. Reset (rst, synchronous) clears
// the stage valid bits only; data registers are not reset.
module double_round_to_integral (
  input logic    clk,
  input logic    rst,
  drti_if.sink   in_ch,
  drti_if.source out_ch
);
  import drti_pkg::*;
  s1_t         s1_d, s1;
  s2_t         s2_d, s2;
  logic [63:0] y_d, y;
  logic        v1, v2, v3, adv;

  assign adv = !v3 || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = v3;
  assign out_ch.data = y;

  drti_decode u_decode (.mode(in_ch.data[66:64]), .x(in_ch.data[63:0]), .s1(s1_d));
  drti_decide u_decide (.s1(s1), .s2(s2_d));
  drti_assemble u_assemble (.s2(s2), .y(y_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_d;
      s2 <= s2_d;
      y <= y_d;
    end
  end
endmodule
